### src/qsc_pkg.sv
// quad_scalar_clip shared package: payload structs, fixed-point widths,
// case tables, edge endpoints and register indexes. No dependencies.
`default_nettype none

package qsc_pkg;

  localparam int DataW      = 32;
  localparam int WeightBits = 16;
  localparam int WeightW    = WeightBits + 1;

  localparam logic [WeightW-1:0] WeightOne = WeightW'(1) << WeightBits;

  // register indexes (byte address = 4 * index)
  localparam logic RegThreshold = 1'b0;
  localparam logic RegInsideOut = 1'b1;

  typedef struct packed {
    logic signed [DataW-1:0] corner_scalar;
    logic signed [DataW-1:0] corner_x;
    logic signed [DataW-1:0] corner_y;
    logic signed [DataW-1:0] corner_z;
  } corner_t;

  typedef struct packed {
    logic signed [DataW-1:0] vertex_x;
    logic signed [DataW-1:0] vertex_y;
    logic signed [DataW-1:0] vertex_z;
    logic [WeightW-1:0]      weight;
    logic [1:0]              from_corner;
    logic [1:0]              to_corner;
    logic                    polygon_end;
    logic                    last;
  } vertex_t;

  // table entry codes: count first, corners 100..103, edges 0..3, end marker
  localparam logic signed [7:0] Nx  = -8'sd1;
  localparam logic signed [7:0] Cr0 = 8'sd100;
  localparam logic signed [7:0] Cr1 = 8'sd101;
  localparam logic signed [7:0] Cr2 = 8'sd102;
  localparam logic signed [7:0] Cr3 = 8'sd103;
  localparam logic signed [7:0] Ed0 = 8'sd0;
  localparam logic signed [7:0] Ed1 = 8'sd1;
  localparam logic signed [7:0] Ed2 = 8'sd2;
  localparam logic signed [7:0] Ed3 = 8'sd3;
  localparam logic signed [7:0] N3  = 8'sd3;
  localparam logic signed [7:0] N4  = 8'sd4;
  localparam logic signed [7:0] N5  = 8'sd5;
  localparam logic signed [7:0] N6  = 8'sd6;
  localparam logic signed [7:0] CodeCorner = Cr0;

  typedef logic [0:8][7:0] tab_row_t;

  localparam tab_row_t TabInside [16] = '{
    '{Nx, Nx,  Nx,  Nx,  Nx,  Nx,  Nx,  Nx, Nx},
    '{N3, Cr0, Ed0, Ed3, Nx,  Nx,  Nx,  Nx, Nx},
    '{N3, Cr1, Ed1, Ed0, Nx,  Nx,  Nx,  Nx, Nx},
    '{N4, Cr0, Cr1, Ed1, Ed3, Nx,  Nx,  Nx, Nx},
    '{N3, Cr2, Ed2, Ed1, Nx,  Nx,  Nx,  Nx, Nx},
    '{N6, Cr0, Ed0, Ed1, Cr2, Ed2, Ed3, Nx, Nx},
    '{N4, Cr1, Cr2, Ed2, Ed0, Nx,  Nx,  Nx, Nx},
    '{N5, Cr0, Cr1, Cr2, Ed2, Ed3, Nx,  Nx, Nx},
    '{N3, Cr3, Ed3, Ed2, Nx,  Nx,  Nx,  Nx, Nx},
    '{N4, Cr0, Ed0, Ed2, Cr3, Nx,  Nx,  Nx, Nx},
    '{N6, Cr1, Ed1, Ed2, Cr3, Ed3, Ed0, Nx, Nx},
    '{N5, Cr0, Cr1, Ed1, Ed2, Cr3, Nx,  Nx, Nx},
    '{N4, Cr2, Cr3, Ed3, Ed1, Nx,  Nx,  Nx, Nx},
    '{N5, Cr0, Ed0, Ed1, Cr2, Cr3, Nx,  Nx, Nx},
    '{N5, Ed0, Cr1, Cr2, Cr3, Ed3, Nx,  Nx, Nx},
    '{N4, Cr0, Cr1, Cr2, Cr3, Nx,  Nx,  Nx, Nx}
  };

  localparam tab_row_t TabOutside [16] = '{
    '{Nx, Nx,  Nx,  Nx,  Nx,  Nx,  Nx,  Nx,  Nx},
    '{N3, Cr0, Ed0, Ed3, Nx,  Nx,  Nx,  Nx,  Nx},
    '{N3, Cr1, Ed1, Ed0, Nx,  Nx,  Nx,  Nx,  Nx},
    '{N4, Cr0, Cr1, Ed1, Ed3, Nx,  Nx,  Nx,  Nx},
    '{N3, Cr2, Ed2, Ed1, Nx,  Nx,  Nx,  Nx,  Nx},
    '{N3, Cr0, Ed0, Ed3, N3,  Cr2, Ed2, Ed1, Nx},
    '{N4, Cr1, Cr2, Ed2, Ed0, Nx,  Nx,  Nx,  Nx},
    '{N5, Cr0, Cr1, Cr2, Ed2, Ed3, Nx,  Nx,  Nx},
    '{N3, Cr3, Ed3, Ed2, Nx,  Nx,  Nx,  Nx,  Nx},
    '{N4, Cr0, Ed0, Ed2, Cr3, Nx,  Nx,  Nx,  Nx},
    '{N3, Cr1, Ed1, Ed0, N3,  Cr3, Ed3, Ed2, Nx},
    '{N5, Cr0, Cr1, Ed1, Ed2, Cr3, Nx,  Nx,  Nx},
    '{N4, Cr2, Cr3, Ed3, Ed1, Nx,  Nx,  Nx,  Nx},
    '{N5, Cr0, Ed0, Ed1, Cr2, Cr3, Nx,  Nx,  Nx},
    '{N5, Ed0, Cr1, Cr2, Cr3, Ed3, Nx,  Nx,  Nx},
    '{N4, Cr0, Cr1, Cr2, Cr3, Nx,  Nx,  Nx,  Nx}
  };

  localparam logic [1:0] EdgeA [4] = '{2'd0, 2'd1, 2'd3, 2'd0};
  localparam logic [1:0] EdgeB [4] = '{2'd1, 2'd2, 2'd2, 2'd3};

  function automatic logic signed [7:0] tab_code(input logic       io,
                                                 input logic [3:0] idx,
                                                 input logic [3:0] pos);
    logic signed [7:0] code;
    if (pos > 4'd8) begin
      code = Nx;
    end else if (io) begin
      code = TabInside[idx][pos];
    end else begin
      code = TabOutside[idx][pos];
    end
    return code;
  endfunction

endpackage

`default_nettype wire

### src/qsc_div.sv
// quad_scalar_clip weight divider: restoring division, one quotient bit per
// cycle, rounded half up and clamped to [0, 1]. Depends on qsc_pkg.
`default_nettype none

module qsc_div
  import qsc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [DataW:0]     num_i,
  input  logic        [DataW:0]     den_i,
  output logic                      done_o,
  output logic        [WeightW-1:0] weight_o
);

  localparam int CntW = $clog2(WeightW);

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DataW:0]      rem_q, den_q;
  logic [WeightW-1:0]  quo_q, w_q;
  logic [DataW+1:0]    shifted, rem_sub;
  logic                ge;
  logic [DataW:0]      rem_nx;
  logic [WeightW-1:0]  quo_nx;
  logic [WeightW:0]    rounded;

  always_comb begin
    shifted = {rem_q, 1'b0};
    ge      = shifted >= {1'b0, den_q};
    rem_sub = shifted - {1'b0, den_q};
    rem_nx  = ge ? rem_sub[DataW:0] : shifted[DataW:0];
    quo_nx  = {quo_q[WeightW-2:0], ge};
    rounded = ({1'b0, quo_nx} + (WeightW+1)'(1)) >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      w_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        den_q <= den_i;
        if (num_i[DataW] || num_i == '0) begin
          w_q    <= '0;
          done_q <= 1'b1;
        end else if (num_i >= $signed(den_i)) begin
          // signed compare: both sides are positive here, so it acts as an unsigned one
          w_q    <= WeightOne;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
          rem_q  <= num_i;
          quo_q  <= '0;
        end
      end else if (busy_q) begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(WeightW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          w_q    <= rounded[WeightW-1:0];
        end
      end
    end
  end

  assign done_o   = done_q;
  assign weight_o = w_q;

endmodule

`default_nettype wire

### src/qsc_mul.sv
// quad_scalar_clip interpolation unit: two-stage pipeline, |end-start| times
// weight, rounded, then added toward the end point. Depends on qsc_pkg.
`default_nettype none

module qsc_mul
  import qsc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic        [1:0]         tag_i,
  input  logic signed [DataW-1:0]   start_i,
  input  logic signed [DataW-1:0]   end_i,
  input  logic        [WeightW-1:0] weight_i,
  output logic                      valid_o,
  output logic        [1:0]         tag_o,
  output logic signed [DataW-1:0]   res_o
);

  localparam int ProdW = DataW + 1 + WeightW;
  localparam logic [ProdW-1:0] Half = ProdW'(1) << (WeightBits - 1);

  logic signed [DataW:0]   diff;
  logic        [DataW:0]   mag;
  logic        [ProdW-1:0] prod_q, rnd_sum;
  logic        [DataW-1:0] qv;
  logic                    neg_q, v1_q, v2_q;
  logic        [1:0]       tag1_q, tag2_q;
  logic signed [DataW-1:0] a_q, res_q;

  always_comb begin
    diff    = {end_i[DataW-1], end_i} - {start_i[DataW-1], start_i};
    mag     = diff[DataW] ? -diff : diff;
    rnd_sum = prod_q + Half;
    qv      = rnd_sum[WeightBits +: DataW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(mag) * ProdW'(weight_i);
    neg_q  <= diff[DataW];
    a_q    <= start_i;
    res_q  <= neg_q ? a_q - $signed(qv) : a_q + $signed(qv);
  end

  assign valid_o = v2_q;
  assign tag_o   = tag2_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

### src/quad_scalar_clip.sv
// quad_scalar_clip top level: APB registers, corner store, table sequencer,
// vertex buffer and output register. Depends on qsc_pkg, qsc_div, qsc_mul.
`default_nettype none

// Clips one quad against a scalar threshold. Corners are taken one
// transaction each, in order 0 to 3. After corner 3 the block is busy:
// it classifies the quad, reads one table row per polygon plus the row that
// ends the walk, writes each original-corner vertex, computes each edge
// vertex (two corner reads, the bit-serial weight divider, three coordinate
// passes through the two-stage multiplier), runs the degenerate check, then
// scans the six buffer slots and returns to idle (slower under output
// stall). The divider and multiplier are shared by all edge vertices.
// Output vertices leave through a registered stage, so the last one
// may still wait there while the next corner transaction is taken.
module quad_scalar_clip
  import qsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  corner_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output vertex_t     out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLASS = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_VCODE = 4'd3;
  localparam logic [3:0] S_RDA   = 4'd4;
  localparam logic [3:0] S_RDB   = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_MULW  = 4'd8;
  localparam logic [3:0] S_DEGEN = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state_q;
  logic signed [DataW-1:0] thr_q;
  logic io_q;
  logic [1:0] ccnt_q;
  logic [3:0] idx_q, pos_q;
  logic [1:0] poly_q;
  logic [2:0] slot_q, vi_q, cnt0_q, cnt1_q, es_q;
  logic [1:0] ea_q, eb_q, mk_q;
  logic [5:0] km_q, pm_q, lm_q;
  logic ov_q;
  vertex_t out_q;

  // corner store and working registers
  logic signed [DataW-1:0] cs_q [4];
  logic signed [DataW-1:0] cx_q [4];
  logic signed [DataW-1:0] cy_q [4];
  logic signed [DataW-1:0] cz_q [4];
  logic signed [DataW-1:0] ca_s_q;
  logic signed [DataW-1:0] ca_p_q [3];
  logic signed [DataW-1:0] ps_q [3];
  logic signed [DataW-1:0] pe_q [3];
  logic [1:0] fr_q, to_q;
  logic [WeightW-1:0] w_q;

  // vertex buffer
  logic signed [DataW-1:0] vx_q [6];
  logic signed [DataW-1:0] vy_q [6];
  logic signed [DataW-1:0] vz_q [6];
  logic [WeightW-1:0] vw_q [6];
  logic [1:0] vf_q [6];
  logic [1:0] vt_q [6];

  logic in_acc, cfg_wr;
  logic [3:0] tpos, class_idx;
  logic signed [7:0] tcode;
  logic code_corner;
  logic [1:0] rd_idx;
  logic signed [DataW-1:0] rd_s, rd_x, rd_y, rd_z;
  logic signed [DataW:0] d_rdb, div_num;
  logic [DataW:0] div_den;
  logic d_pos, d_zero, div_start, div_done;
  logic signed [DataW-1:0] s_scal;
  logic [WeightW-1:0] div_w;
  logic [2:0] cur_cnt;
  logic vert_done, last_vert, fetch_ok, emit_load;
  logic mul_v;
  logic [1:0] mul_tag;
  logic signed [DataW-1:0] mul_res;
  logic [5:0][5:0] eqm;
  logic [3:0] pairs;
  logic deg0, keep0, keep1, hi;
  logic [5:0] km_d, pm_d, lm_d;
  logic [3:0] end1;

  assign in_acc = in_valid_i && in_ready_o;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    tpos        = (state_q == S_FETCH) ? pos_q : pos_q + 4'(vi_q) + 4'd1;
    tcode       = tab_code(io_q, idx_q, tpos);
    code_corner = tcode >= CodeCorner;
    case (state_q)
      S_VCODE: rd_idx = tcode[1:0];
      S_RDA:   rd_idx = ea_q;
      default: rd_idx = eb_q;
    endcase
    rd_s = cs_q[rd_idx];
    rd_x = cx_q[rd_idx];
    rd_y = cy_q[rd_idx];
    rd_z = cz_q[rd_idx];

    d_rdb   = {rd_s[DataW-1], rd_s} - {ca_s_q[DataW-1], ca_s_q};
    d_zero  = d_rdb == '0;
    d_pos   = !d_rdb[DataW] && !d_zero;
    s_scal  = d_pos ? ca_s_q : rd_s;
    div_num = {thr_q[DataW-1], thr_q} - {s_scal[DataW-1], s_scal};
    div_den = d_pos ? d_rdb : -d_rdb;
    div_start = (state_q == S_RDB) && !d_zero;

    for (int i = 0; i < 4; i++) begin
      class_idx[i] = io_q ? (cs_q[i] <= thr_q) : (cs_q[i] > thr_q);
    end

    cur_cnt   = (poly_q == 2'd0) ? cnt0_q : cnt1_q;
    vert_done = ((state_q == S_VCODE) && code_corner) ||
                ((state_q == S_MULW) && mul_v && mul_tag == 2'd2);
    last_vert = (vi_q + 3'd1) == cur_cnt;
    fetch_ok  = (poly_q != 2'd2) && (tcode >= N3) && (tcode <= N6) &&
                (({1'b0, pos_q} + 5'(tcode[2:0])) <= 5'd8);
    emit_load = (state_q == S_EMIT) && (es_q < 3'd6) && km_q[es_q] &&
                (!ov_q || out_ready_i);
  end

  // degenerate polygon check over the whole buffer
  always_comb begin
    for (int p = 0; p < 6; p++) begin
      for (int q = 0; q < 6; q++) begin
        eqm[p][q] = (vx_q[p] == vx_q[q]) && (vy_q[p] == vy_q[q]) &&
                    (vz_q[p] == vz_q[q]);
      end
    end
    pairs = '0;
    for (int p = 1; p < 6; p++) begin
      for (int q = 0; q < p; q++) begin
        if ((3'(p) < cnt0_q) && eqm[p][q]) begin
          pairs = pairs + 4'd1;
        end
      end
    end
    case (cnt0_q)
      3'd3:    deg0 = eqm[0][1] || eqm[0][2] || eqm[1][2];
      3'd4:    deg0 = (eqm[0][3] && eqm[1][2]) || (eqm[0][1] && eqm[3][2]);
      3'd5,
      3'd6:    deg0 = pairs >= 4'(cnt0_q - 3'd2);
      default: deg0 = 1'b1;
    endcase
    keep0 = (cnt0_q != 3'd0) && !deg0;
    // a second polygon only follows a triangle, so it sits in slots 3 to 5
    keep1 = (cnt1_q != 3'd0) && !(eqm[3][4] || eqm[3][5] || eqm[4][5]);
    end1  = 4'(cnt0_q) + 4'(cnt1_q);
    for (int s = 0; s < 6; s++) begin
      km_d[s] = ((3'(s) < cnt0_q) && keep0) ||
                ((3'(s) >= cnt0_q) && (4'(s) < end1) && keep1);
      pm_d[s] = ((3'(s) + 3'd1) == cnt0_q) || ((4'(s) + 4'd1) == end1);
    end
    hi = 1'b0;
    for (int s = 5; s >= 0; s--) begin
      lm_d[s] = km_d[s] && !hi;
      hi      = hi || km_d[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      thr_q   <= '0;
      io_q    <= 1'b0;
      ccnt_q  <= '0;
      idx_q   <= '0;
      pos_q   <= '0;
      poly_q  <= '0;
      slot_q  <= '0;
      vi_q    <= '0;
      cnt0_q  <= '0;
      cnt1_q  <= '0;
      es_q    <= '0;
      ea_q    <= '0;
      eb_q    <= '0;
      mk_q    <= '0;
      km_q    <= '0;
      pm_q    <= '0;
      lm_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          RegThreshold: thr_q <= pwdata;
          RegInsideOut: io_q  <= pwdata[0];
          default:      io_q  <= io_q;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            ccnt_q <= ccnt_q + 2'd1;
            if (ccnt_q == 2'd3) begin
              state_q <= S_CLASS;
            end
          end
        end
        S_CLASS: begin
          idx_q   <= class_idx;
          pos_q   <= '0;
          poly_q  <= '0;
          slot_q  <= '0;
          vi_q    <= '0;
          cnt0_q  <= '0;
          cnt1_q  <= '0;
          state_q <= S_FETCH;
        end
        S_FETCH: begin
          if (fetch_ok) begin
            if (poly_q == 2'd0) begin
              cnt0_q <= tcode[2:0];
            end else begin
              cnt1_q <= tcode[2:0];
            end
            vi_q    <= '0;
            state_q <= S_VCODE;
          end else begin
            state_q <= S_DEGEN;
          end
        end
        S_VCODE: begin
          if (!code_corner) begin
            ea_q    <= EdgeA[tcode[1:0]];
            eb_q    <= EdgeB[tcode[1:0]];
            state_q <= S_RDA;
          end
        end
        S_RDA: begin
          state_q <= S_RDB;
        end
        S_RDB: begin
          mk_q    <= '0;
          state_q <= d_zero ? S_MUL : S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            mk_q    <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          mk_q <= mk_q + 2'd1;
          if (mk_q == 2'd2) begin
            state_q <= S_MULW;
          end
        end
        S_MULW: begin
          // leaves through the vertex-done path
        end
        S_DEGEN: begin
          km_q    <= km_d;
          pm_q    <= pm_d;
          lm_q    <= lm_d;
          es_q    <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (es_q >= 3'd6) begin
            state_q <= S_IDLE;
          end else if (!km_q[es_q] || emit_load) begin
            es_q <= es_q + 3'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (vert_done) begin
        slot_q <= slot_q + 3'd1;
        vi_q   <= vi_q + 3'd1;
        if (last_vert) begin
          pos_q   <= pos_q + 4'(cur_cnt) + 4'd1;
          poly_q  <= poly_q + 2'd1;
          state_q <= S_FETCH;
        end else begin
          state_q <= S_VCODE;
        end
      end

      if (emit_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cs_q[ccnt_q] <= in_data_i.corner_scalar;
      cx_q[ccnt_q] <= in_data_i.corner_x;
      cy_q[ccnt_q] <= in_data_i.corner_y;
      cz_q[ccnt_q] <= in_data_i.corner_z;
    end
    if (state_q == S_RDA) begin
      ca_s_q    <= rd_s;
      ca_p_q[0] <= rd_x;
      ca_p_q[1] <= rd_y;
      ca_p_q[2] <= rd_z;
    end
    if (state_q == S_RDB) begin
      // the edge runs from the lower scalar, second endpoint on a tie
      if (d_pos) begin
        ps_q <= ca_p_q;
        pe_q <= '{rd_x, rd_y, rd_z};
        fr_q <= ea_q;
        to_q <= eb_q;
      end else begin
        ps_q <= '{rd_x, rd_y, rd_z};
        pe_q <= ca_p_q;
        fr_q <= eb_q;
        to_q <= ea_q;
      end
      w_q <= '0;
    end
    if ((state_q == S_DIVW) && div_done) begin
      w_q <= div_w;
    end
    if (mul_v) begin
      case (mul_tag)
        2'd0:    vx_q[slot_q] <= mul_res;
        2'd1:    vy_q[slot_q] <= mul_res;
        default: vz_q[slot_q] <= mul_res;
      endcase
    end
    if (vert_done) begin
      if (state_q == S_VCODE) begin
        vx_q[slot_q] <= rd_x;
        vy_q[slot_q] <= rd_y;
        vz_q[slot_q] <= rd_z;
        vw_q[slot_q] <= '0;
        vf_q[slot_q] <= rd_idx;
        vt_q[slot_q] <= rd_idx;
      end else begin
        vw_q[slot_q] <= w_q;
        vf_q[slot_q] <= fr_q;
        vt_q[slot_q] <= to_q;
      end
    end
    if (emit_load) begin
      out_q.vertex_x    <= vx_q[es_q];
      out_q.vertex_y    <= vy_q[es_q];
      out_q.vertex_z    <= vz_q[es_q];
      out_q.weight      <= vw_q[es_q];
      out_q.from_corner <= vf_q[es_q];
      out_q.to_corner   <= vt_q[es_q];
      out_q.polygon_end <= pm_q[es_q];
      out_q.last        <= lm_q[es_q];
    end
  end

  qsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .weight_o(div_w)
  );

  qsc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (state_q == S_MUL),
    .tag_i   (mk_q),
    .start_i (ps_q[mk_q]),
    .end_i   (pe_q[mk_q]),
    .weight_i(w_q),
    .valid_o (mul_v),
    .tag_o   (mul_tag),
    .res_o   (mul_res)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == RegInsideOut) ? {31'b0, io_q} : thr_q;

endmodule

`default_nettype wire

### src/qsc_checker.sv
// quad_scalar_clip port checker with its bind statement.
// Depends on qsc_pkg and the quad_scalar_clip top level.
`default_nettype none

module qsc_checker
  import qsc_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input vertex_t out_data_o,
  input logic    pready
);

  // a stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output payload changed under stall");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.weight <= WeightOne)
    else $error("weight above one");

  // an original corner carries zero weight
  a_corner_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.from_corner == out_data_o.to_corner
      |-> out_data_o.weight == '0)
    else $error("corner vertex with nonzero weight");

  // the last vertex of a quad also closes a polygon
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.polygon_end)
    else $error("last vertex does not end a polygon");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind quad_scalar_clip qsc_checker u_qsc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o),
  .pready     (pready)
);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for quad_scalar_clip: computes the expected vertices
// of each quad and compares them with the output stream. Depends on qsc_pkg and quad_scalar_clip.
module tb_top;
  import qsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 200;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  corner_t in_data;
  vertex_t out_data;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  quad_scalar_clip i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic signed [DataW-1:0] thr_q;
  logic inside_q;
  int unsigned slot_q;
  logic signed [DataW-1:0] sc_q [4];
  logic signed [DataW-1:0] xyz_q [4][3];

  vertex_t vertex_queue [$];
  int errors;
  int cycles;
  int send_idle, recv_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp, cycles);
  endtask

  // output side: random stall and checking
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (vertex_queue.size() == 0) begin
          report("unexpected vertex", out_data, 0);
        end else begin
          e = vertex_queue.pop_front();
          if (out_data.vertex_x !== e.vertex_x) report("vertex_x", out_data.vertex_x, e.vertex_x);
          if (out_data.vertex_y !== e.vertex_y) report("vertex_y", out_data.vertex_y, e.vertex_y);
          if (out_data.vertex_z !== e.vertex_z) report("vertex_z", out_data.vertex_z, e.vertex_z);
          if (out_data.weight !== e.weight) report("weight", out_data.weight, e.weight);
          if (out_data.from_corner !== e.from_corner)
            report("from_corner", out_data.from_corner, e.from_corner);
          if (out_data.to_corner !== e.to_corner)
            report("to_corner", out_data.to_corner, e.to_corner);
          if (out_data.polygon_end !== e.polygon_end)
            report("polygon_end", out_data.polygon_end, e.polygon_end);
          if (out_data.last !== e.last) report("last", out_data.last, e.last);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic [WeightW-1:0] edge_weight(input logic signed [DataW:0] num,
                                                     input logic [DataW:0] den);
    logic [DataW+1:0] r;
    logic [WeightW:0] q;
    q = '0;
    if (num <= 0) return '0;
    r = {1'b0, num};
    if (r >= {1'b0, den}) return WeightOne;
    for (int i = 0; i <= WeightBits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= {1'b0, den}) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return WeightW'((q + 1) >> 1);
  endfunction

  function automatic logic signed [DataW-1:0] lerp(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW-1:0] b,
                                                   input logic [WeightW-1:0] w);
    longint d, m, ph, pl, q;
    d = longint'(b) - longint'(a);
    m = (d < 0) ? -d : d;
    ph = (m >> 24) * w;
    pl = (m & 64'hFFFFFF) * w;
    q = (ph << (24 - WeightBits)) + ((pl + (1 << (WeightBits - 1))) >> WeightBits);
    return (d < 0) ? DataW'(longint'(a) - q) : DataW'(longint'(a) + q);
  endfunction

  function automatic logic same(input logic signed [DataW-1:0] p [6][3],
                                input int i, input int j);
    return p[i][0] == p[j][0] && p[i][1] == p[j][1] && p[i][2] == p[j][2];
  endfunction

  // works out the vertices of a complete quad and queues them
  task automatic predict_quad();
    logic [3:0] idx;
    logic signed [7:0] code;
    logic signed [DataW-1:0] pb [6][3];
    vertex_t vb [6];
    vertex_t outv [$];
    int pos, cnt, pairs, sa, sb;
    logic dropped;
    logic [WeightW-1:0] w;
    longint d;
    idx = '0;
    for (int i = 0; i < 4; i++)
      idx[i] = inside_q ? (sc_q[i] <= thr_q) : (sc_q[i] > thr_q);
    pos = 0;
    while (pos < 9) begin
      code = inside_q ? TabInside[idx][pos] : TabOutside[idx][pos];
      cnt = code;
      if (cnt < 3 || cnt > 6 || pos + cnt > 8) break;
      for (int i = 0; i < cnt; i++) begin
        code = inside_q ? TabInside[idx][pos+1+i] : TabOutside[idx][pos+1+i];
        vb[i] = '0;
        if (code >= CodeCorner) begin
          sa = code - CodeCorner;
          for (int k = 0; k < 3; k++) pb[i][k] = xyz_q[sa][k];
          vb[i].from_corner = sa;
          vb[i].to_corner = sa;
        end else begin
          sa = EdgeA[code];
          sb = EdgeB[code];
          d = longint'(sc_q[sb]) - longint'(sc_q[sa]);
          if (d <= 0) begin
            int t;
            t = sa; sa = sb; sb = t;
            d = -d;
          end
          w = (d == 0) ? '0 :
              edge_weight((DataW+1)'(longint'(thr_q) - longint'(sc_q[sa])),
                          (DataW+1)'(d));
          for (int k = 0; k < 3; k++) pb[i][k] = lerp(xyz_q[sa][k], xyz_q[sb][k], w);
          vb[i].weight = w;
          vb[i].from_corner = sa;
          vb[i].to_corner = sb;
        end
        vb[i].vertex_x = pb[i][0];
        vb[i].vertex_y = pb[i][1];
        vb[i].vertex_z = pb[i][2];
        vb[i].polygon_end = (i == cnt - 1);
      end
      if (cnt == 3) dropped = same(pb, 0, 1) || same(pb, 0, 2) || same(pb, 1, 2);
      else if (cnt == 4)
        dropped = (same(pb, 0, 3) && same(pb, 1, 2)) || (same(pb, 0, 1) && same(pb, 3, 2));
      else begin
        pairs = 0;
        for (int p = 1; p < cnt; p++)
          for (int q = 0; q < p; q++)
            if (same(pb, p, q)) pairs++;
        dropped = pairs >= cnt - 2;
      end
      if (!dropped && outv.size() + cnt <= 6)
        for (int i = 0; i < cnt; i++) outv.push_back(vb[i]);
      pos += cnt + 1;
    end
    if (outv.size() > 0) outv[outv.size()-1].last = 1'b1;
    foreach (outv[i]) vertex_queue.push_back(outv[i]);
  endtask

  // valid stays high between back-to-back transactions and drops on idle cycles
  task automatic send_corner(input corner_t c);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    sc_q[slot_q] = c.corner_scalar;
    xyz_q[slot_q][0] = c.corner_x;
    xyz_q[slot_q][1] = c.corner_y;
    xyz_q[slot_q][2] = c.corner_z;
    if (slot_q == 3) predict_quad();
    slot_q = (slot_q + 1) % 4;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic signed [31:0] thr, input logic io);
    wait_idle();
    write_reg(3'(4 * RegThreshold), thr);
    write_reg(3'(4 * RegInsideOut), {31'd0, io});
    thr_q = thr;
    inside_q = io;
  endtask

  function automatic logic [31:0] rand_val(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'(signed'($urandom_range(8)) - 4) <<< 16;
      default: return 32'(signed'($urandom_range(400)) - 200);
    endcase
  endfunction

  task automatic send_quad(input logic [31:0] s0, s1, s2, s3, input int mode);
    logic [31:0] s [4];
    corner_t c;
    s = '{s0, s1, s2, s3};
    for (int i = 0; i < 4; i++) begin
      c.corner_scalar = s[i];
      c.corner_x = rand_val(mode);
      c.corner_y = rand_val(mode);
      c.corner_z = rand_val(mode);
      send_corner(c);
    end
  endtask

  task automatic test_directed();
    logic [31:0] lo, hi;
    lo = 32'h8000_0000;
    hi = 32'h7FFF_FFFF;
    send_idle = 0; recv_stall = 0;
    for (int io = 0; io < 2; io++) begin
      set_config(0, io);
      // all sixteen cases in both modes; two extreme quads follow
      for (int k = 0; k < 16; k++)
        send_quad(k[0] ? 32'h10000 : -32'sh10000, k[1] ? 32'h20000 : -32'sh8000,
                  k[2] ? 32'h30000 : -32'sh30000, k[3] ? 32'h8000 : -32'sh1, 0);
    end
    set_config(hi, 1'b0);
    send_quad(lo, hi, lo, hi, 0);
    set_config(lo, 1'b1);
    send_quad(lo, lo, hi, 0, 0);
    // equal scalars on an edge and coincident points
    set_config(32'h10000, 1'b1);
    send_quad(0, 0, 32'h20000, 32'h20000, 1);
    send_quad(32'h10000, 0, 32'h10000, 32'h20000, 2);
  endtask

  task automatic test_random(input int quads, input int idle, input int stall);
    send_idle = idle; recv_stall = stall;
    for (int q = 0; q < quads; q++) begin
      int mode;
      mode = $urandom_range(2);
      if (mode == 0) send_quad($urandom(), $urandom(), $urandom(), $urandom(), 0);
      else send_quad(rand_val(mode), rand_val(mode), rand_val(mode), rand_val(mode), mode);
    end
  endtask

  task automatic test_pause();
    send_quad(32'h30000, -32'sh20000, 32'h10000, -32'sh10000, 2);
    in_valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    send_quad(-32'sh30000, 32'h20000, -32'sh10000, 32'h10000, 2);
  endtask

  initial begin
    errors = 0; cycles = 0; slot_q = 0;
    thr_q = '0; inside_q = 1'b0;
    in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle = 0; recv_stall = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_config(32'h0, 1'b0);
    test_random(8, 0, 0);
    set_config(32'(signed'($urandom_range(8)) - 4) <<< 16, 1'b1);
    test_random(8, 79, 0);
    test_pause();
    set_config($urandom(), 1'b0);
    test_random(8, 0, 79);
    set_config(-32'sh20000, 1'b1);
    test_random(8, 37, 37);
    send_idle = 0; recv_stall = 0;
    in_valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### sim.f
src/qsc_pkg.sv
src/qsc_div.sv
src/qsc_mul.sv
src/quad_scalar_clip.sv
src/qsc_checker.sv
tb/sv/tb_top.sv
